@@ src/ubx_frame_receiver_unit_macros.svh @@
// Assertion macros shared by the receiver RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef UBX_FRAME_RECEIVER_UNIT_MACROS_SVH
`define UBX_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define UBXFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UBXFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ubxfr_pkg.sv @@
// Types, codes and helper functions for the UBX frame receiver.
// No dependencies; used by ubxfr_core and ubx_frame_receiver_unit.
package ubxfr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 256;

  localparam logic [7:0] SYNC_CHAR1 = 8'hB5;
  localparam logic [7:0] SYNC_CHAR2 = 8'h62;
  localparam logic [7:0] CLS_ACK    = 8'h05;
  localparam logic [7:0] CLS_NAV    = 8'h01;
  localparam logic [7:0] ID_PVT     = 8'h07;
  localparam logic [7:0] ID_ACK     = 8'h01;
  localparam logic [7:0] ID_NAK     = 8'h00;
  localparam logic [15:0] PVT_LEN   = 16'd92;

  // payload bytes 24..35 of a PVT frame hold lon, lat, height
  localparam int unsigned PVT_BASE  = 24;
  localparam int unsigned PVT_BYTES = 12;

  // frame position saturates once past the header bytes
  localparam logic [3:0] FP_SAT = 4'd8;

  localparam logic [1:0] CFG_REQ_CLASS = 2'd0;
  localparam logic [1:0] CFG_REQ_ID    = 2'd1;
  localparam logic [1:0] CFG_START_OFS = 2'd2;

  typedef enum logic [1:0] {CTX_SCRATCH, CTX_DATA, CTX_ACK} ctx_t;
  typedef enum logic [1:0] {FS_IDLE, FS_GOOD, FS_BAD, FS_ABORT} fstat_t;
  typedef enum logic [1:0] {MS_NONE, MS_MATCH, MS_NACK, MS_BAD} mstat_t;

  typedef struct packed {
    fstat_t             frame_status;
    mstat_t             match_status;
    ctx_t               ctx;
    logic [7:0]         cls;
    logic [7:0]         id;
    logic               store_valid;
    logic [7:0]         store_index;
    logic [7:0]         store_byte;
    logic               pos_update;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] altitude;
  } ubxfr_res_t;

  function automatic logic sib_pvt(input logic [7:0] id, input logic [7:0] rid);
    logic r;
    r = 1'b0;
    if (id == 8'h07) r = (rid == 8'h14) || (rid == 8'h04);
    else if (id == 8'h14) r = (rid == 8'h07) || (rid == 8'h04);
    else if (id == 8'h04) r = (rid == 8'h07) || (rid == 8'h14);
    return r;
  endfunction

  function automatic logic sib_hnr(input logic [7:0] id, input logic [7:0] rid);
    logic r;
    r = 1'b0;
    if (id == 8'h01) r = (rid == 8'h02) || (rid == 8'h00);
    else if (id == 8'h02) r = (rid == 8'h01) || (rid == 8'h00);
    else if (id == 8'h00) r = (rid == 8'h01) || (rid == 8'h02);
    return r;
  endfunction

endpackage

@@ src/ubxfr_core.sv @@
// Frame parser state and per-beat result logic for the UBX receiver.
// Depends on ubxfr_pkg.
module ubxfr_core import ubxfr_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] req_class,
  input  logic [7:0] req_id,
  input  logic [7:0] start_ofs,
  output ubxfr_res_t res
);

  localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int unsigned IW = (CW > 8) ? CW : 8;

  logic          in_ubx_r, in_ubx_nxt;
  logic [3:0]    fp_r, fp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ctx_t          ctx_r, ctx_nxt;
  logic          ign_r, ign_nxt;
  logic [7:0]    sa_r, sa_nxt, sb_r, sb_nxt;
  logic [7:0]    cls_r, cls_nxt, id_r, id_nxt, cka_r, cka_nxt, start_r, start_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [7:0]    sp_r [4];
  logic [7:0]    sp_nxt [4];
  logic [7:0]    sh_r [PVT_BYTES];
  logic [7:0]    sh_nxt [PVT_BYTES];
  logic [31:0]   pos_r [3];
  logic [31:0]   pos_nxt [3];

  logic          enter, act, done, good, req, ackm, nav, overrun;
  logic [16:0]   lenp4, cntx;
  logic [IW-1:0] idx, off, st;
  logic [7:0]    pay0, pay1;
  logic [3:0]    shi;

  always_comb begin
    in_ubx_nxt = in_ubx_r;
    fp_nxt     = fp_r;
    cnt_nxt    = cnt_r;
    ctx_nxt    = ctx_r;
    ign_nxt    = ign_r;
    sa_nxt     = sa_r;
    sb_nxt     = sb_r;
    cls_nxt    = cls_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    cka_nxt    = cka_r;
    start_nxt  = start_r;
    sp_nxt     = sp_r;
    sh_nxt     = sh_r;
    pos_nxt    = pos_r;
    res        = '0;
    done       = 1'b0;
    good       = 1'b0;
    req        = 1'b0;
    ackm       = 1'b0;
    nav        = 1'b0;
    overrun    = 1'b0;
    lenp4      = '0;
    cntx       = '0;
    idx        = '0;
    off        = '0;
    st         = '0;
    pay0       = '0;
    pay1       = '0;
    shi        = '0;

    // NMEA and RTCM starts need no tracking: every byte outside UBX is checked for sync
    enter = !in_ubx_r && (rx_byte == SYNC_CHAR1);
    act   = in_ubx_r || enter;
    if (enter) begin
      in_ubx_nxt = 1'b1;
      fp_nxt     = '0;
      cnt_nxt    = '0;
      ign_nxt    = 1'b0;
      ctx_nxt    = CTX_SCRATCH;
    end

    if (act) begin
      unique case (fp_nxt)
        4'd1: begin
          if (rx_byte != SYNC_CHAR2) in_ubx_nxt = 1'b0;
        end
        4'd2: begin
          cls_nxt   = rx_byte;
          sa_nxt    = '0;
          sb_nxt    = '0;
          cnt_nxt   = '0;
          start_nxt = start_ofs;
        end
        4'd3: begin
          id_nxt = rx_byte;
          if (cls_nxt != CLS_ACK) begin
            if (cls_nxt == req_class && (id_nxt == req_id || sib_pvt(id_nxt, req_id) ||
                sib_hnr(id_nxt, req_id))) begin
              ctx_nxt = CTX_DATA;
            end else begin
              ign_nxt = 1'b1;
            end
          end
        end
        4'd4: len_nxt = {8'h00, rx_byte};
        4'd5: len_nxt[15:8] = rx_byte;
        4'd6: begin
          if (len_nxt == 16'd0) cka_nxt = rx_byte;
          else sp_nxt[0] = rx_byte;
        end
        4'd7: begin
          if (len_nxt == 16'd1) cka_nxt = rx_byte;
          else if (len_nxt >= 16'd2) sp_nxt[1] = rx_byte;
          if (ctx_nxt == CTX_SCRATCH && cls_nxt == CLS_ACK && sp_nxt[0] == req_class &&
              sp_nxt[1] == req_id && len_nxt == 16'd2) begin
            ctx_nxt   = CTX_ACK;
            sp_nxt[2] = sp_nxt[0];
            sp_nxt[3] = sp_nxt[1];
          end
        end
        default: ;
      endcase

      lenp4 = {1'b0, len_nxt} + 17'd4;
      cntx  = 17'(cnt_nxt);
      if (cntx < lenp4) begin
        sa_nxt = sa_nxt + rx_byte;
        sb_nxt = sb_nxt + sa_nxt;
      end

      priority if (cnt_nxt == CW'(0)) cls_nxt = rx_byte;
      else if (cnt_nxt == CW'(1)) id_nxt = rx_byte;
      else if (cnt_nxt == CW'(2)) len_nxt = {8'h00, rx_byte};
      else if (cnt_nxt == CW'(3)) len_nxt[15:8] = rx_byte;
      else if (cntx == lenp4) cka_nxt = rx_byte;
      else if (cntx == lenp4 + 17'd1) begin
        done       = 1'b1;
        in_ubx_nxt = 1'b0;
        good = (cka_nxt == sa_nxt) && (rx_byte == sb_nxt);
        req  = (cls_nxt == req_class) && (id_nxt == req_id);
        pay0 = (ctx_nxt == CTX_ACK) ? sp_nxt[2] : sp_nxt[0];
        pay1 = (ctx_nxt == CTX_ACK) ? sp_nxt[3] : sp_nxt[1];
        ackm = (cls_nxt == CLS_ACK) && (ctx_nxt != CTX_DATA) && (pay0 == req_class) &&
               (pay1 == req_id);
        if (good) begin
          res.frame_status = FS_GOOD;
          if (req) res.match_status = MS_MATCH;
          else if (ackm && id_nxt == ID_ACK) res.match_status = MS_MATCH;
          else if (ackm && id_nxt == ID_NAK) res.match_status = MS_NACK;
          if (!ign_nxt && cls_nxt == CLS_NAV && id_nxt == ID_PVT && len_nxt == PVT_LEN) begin
            pos_nxt[0] = {sh_nxt[3], sh_nxt[2], sh_nxt[1], sh_nxt[0]};
            pos_nxt[1] = {sh_nxt[7], sh_nxt[6], sh_nxt[5], sh_nxt[4]};
            pos_nxt[2] = {sh_nxt[11], sh_nxt[10], sh_nxt[9], sh_nxt[8]};
            res.pos_update = 1'b1;
          end
        end else begin
          res.frame_status = FS_BAD;
          if (req || ackm) res.match_status = MS_BAD;
        end
      end else begin
        nav = (cls_nxt == CLS_NAV) && (id_nxt == ID_PVT);
        if (nav || ctx_nxt == CTX_ACK) st = '0;
        else if (ctx_nxt == CTX_DATA) st = IW'(start_ofs);
        else st = IW'(start_nxt);
        idx = IW'(cnt_nxt) - IW'(4);
        if (!ign_nxt && idx >= st) begin
          off = idx - st;
          if ((ctx_nxt == CTX_DATA) ? (off < IW'(PAYLOAD_DEPTH)) : (off < IW'(2))) begin
            if (ctx_nxt == CTX_DATA) begin
              if (off >= IW'(PVT_BASE) && off < IW'(PVT_BASE + PVT_BYTES)) begin
                shi = 4'(off - IW'(PVT_BASE));
                sh_nxt[shi] = rx_byte;
              end
            end else if (ctx_nxt == CTX_ACK) begin
              sp_nxt[{1'b1, off[0]}] = rx_byte;
            end else begin
              sp_nxt[{1'b0, off[0]}] = rx_byte;
            end
            res.store_valid = 1'b1;
            res.store_index = off[7:0];
            res.store_byte  = rx_byte;
          end else begin
            overrun = 1'b1;
          end
        end
      end

      cnt_nxt = cnt_nxt + CW'(1);
      if (overrun || cnt_nxt == CW'(PAYLOAD_DEPTH)) begin
        in_ubx_nxt = 1'b0;
        if (!done) res.frame_status = FS_ABORT;
      end
      if (fp_nxt != FP_SAT) fp_nxt = fp_nxt + 4'd1;

      res.ctx = ctx_nxt;
      res.cls = cls_nxt;
      res.id  = id_nxt;
    end

    res.longitude = pos_nxt[0];
    res.latitude  = pos_nxt[1];
    res.altitude  = pos_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ubx_r <= 1'b0;
      fp_r     <= '0;
      cnt_r    <= '0;
      ctx_r    <= CTX_SCRATCH;
      ign_r    <= 1'b0;
      sa_r     <= '0;
      sb_r     <= '0;
      cls_r    <= '0;
      id_r     <= '0;
      len_r    <= '0;
      cka_r    <= '0;
      start_r  <= '0;
      sp_r     <= '{default: '0};
      pos_r    <= '{default: '0};
    end else if (step) begin
      in_ubx_r <= in_ubx_nxt;
      fp_r     <= fp_nxt;
      cnt_r    <= cnt_nxt;
      ctx_r    <= ctx_nxt;
      ign_r    <= ign_nxt;
      sa_r     <= sa_nxt;
      sb_r     <= sb_nxt;
      cls_r    <= cls_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      cka_r    <= cka_nxt;
      start_r  <= start_nxt;
      sp_r     <= sp_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) sh_r <= sh_nxt;
  end

endmodule

@@ src/ubx_frame_receiver_unit.sv @@
// UBX frame receiver top level: beat registers, config registers, parser core.
// Depends on ubxfr_pkg, ubxfr_core and ubx_frame_receiver_unit_macros.svh.
//
// Usage: one received byte per beat on the in_ channel (in_valid/in_ready).
// Each byte gives exactly one result beat on the out_ channel: frame and
// match status, context, class/id, the payload store write and the current
// position (lon, lat, height from the last good NAV-PVT frame).
// An accepted input beat is held in the input register, which feeds a single
// parse pass straight into the result register. Throughput is one byte per
// cycle while out_ready is high; the parse step is compares and adds.
// The input register takes a new byte while a finished result waits.
// If out_ready stays low the result and the input register hold, and
// in_ready drops once both are full; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both registers, returns the
// parser to sync hunting and sets requested class 0x01, id 0x07, start
// offset 0. The cfg_ channel is always ready; writes take effect at once
// and belong between frames or while the block is idle.
// Payload bytes appear on the store_ outputs for a host-side buffer.
`include "ubx_frame_receiver_unit_macros.svh"
module ubx_frame_receiver_unit import ubxfr_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic [1:0]         out_match_status,
  output logic [1:0]         out_context_used,
  output logic [7:0]         out_msg_class,
  output logic [7:0]         out_msg_id,
  output logic               out_store_valid,
  output logic [7:0]         out_store_index,
  output logic [7:0]         out_store_byte,
  output logic               out_position_update,
  output logic signed [31:0] out_longitude,
  output logic signed [31:0] out_latitude,
  output logic signed [31:0] out_altitude,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  ubxfr_res_t res_r, res_c;
  logic [7:0] req_class_r, req_id_r, start_ofs_r;
  logic       adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  ubxfr_core #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .rx_byte   (s1_byte_r),
    .req_class (req_class_r),
    .req_id    (req_id_r),
    .start_ofs (start_ofs_r),
    .res       (res_c)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      req_class_r <= CLS_NAV;
      req_id_r    <= ID_PVT;
      start_ofs_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_REQ_CLASS: req_class_r <= cfg_data;
          CFG_REQ_ID:    req_id_r    <= cfg_data;
          CFG_START_OFS: start_ofs_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_rx_byte;
    if (adv) res_r <= res_c;
  end

  assign out_valid           = out_valid_r;
  assign out_frame_status    = res_r.frame_status;
  assign out_match_status    = res_r.match_status;
  assign out_context_used    = res_r.ctx;
  assign out_msg_class       = res_r.cls;
  assign out_msg_id          = res_r.id;
  assign out_store_valid     = res_r.store_valid;
  assign out_store_index     = res_r.store_index;
  assign out_store_byte      = res_r.store_byte;
  assign out_position_update = res_r.pos_update;
  assign out_longitude       = res_r.longitude;
  assign out_latitude        = res_r.latitude;
  assign out_altitude        = res_r.altitude;

  `UBXFR_ASSERT_IMP(a_store_not_at_end, out_valid_r && res_r.store_valid,
    res_r.frame_status != FS_GOOD && res_r.frame_status != FS_BAD, "store on checksum beat")
  `UBXFR_ASSERT_IMP(a_pos_from_data, out_valid_r && res_r.pos_update,
    res_r.frame_status == FS_GOOD && res_r.ctx == CTX_DATA, "position update off good data")
  `UBXFR_ASSERT_IMP(a_match_at_end, out_valid_r && res_r.match_status != MS_NONE,
    res_r.frame_status == FS_GOOD || res_r.frame_status == FS_BAD, "match without frame end")
  `UBXFR_ASSERT_NXT(a_s1_hold, s1_valid_r && !adv,
    s1_valid_r && $stable(s1_byte_r), "input register lost a stalled byte")

endmodule
